FILE: rtl/wms_pkg.sv
`timescale 1ns / 1ps

package wms_pkg;

   localparam int WHEELS_DEF = 4;
   localparam int MAX_WHEELS = 4;

   localparam int VEL_W   = 16;
   localparam int GAIN_W  = 16;
   localparam int ROW_W   = 48;
   localparam int SCALE_W = 8;
   localparam int STEP_W  = 16;
   localparam int LEVEL_W = 32;

   // Velocity times speed scale fits in 25 bits; gain times that in 41 bits;
   // the sum of three such products in 43 bits.
   localparam int SVEL_W = 25;
   localparam int PROD_W = 41;
   localparam int ACC_W  = 43;
   localparam int DIFF_W = LEVEL_W + 1;

   localparam int PC_W      = 4;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = ROW_W;

   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_ROW_0  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SPEED_SCALE = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SLEW_STEP   = 3'd5;

   localparam logic OP_COMMAND = 1'b0;
   localparam logic OP_TICK    = 1'b1;

   localparam logic [SCALE_W-1:0] SPEED_SCALE_RST = 8'd1;
   localparam logic [STEP_W-1:0]  SLEW_STEP_RST   = 16'd100;

   // Axis codes select both the velocity and the matching gain field.
   localparam logic [1:0] VEL_X = 2'd0;
   localparam logic [1:0] VEL_Y = 2'd1;
   localparam logic [1:0] VEL_R = 2'd2;

   // Program entry points.
   localparam logic [PC_W-1:0] UC_CMD  = 4'd0;
   localparam logic [PC_W-1:0] UC_MIX  = 4'd4;
   localparam logic [PC_W-1:0] UC_TICK = 4'd10;

   typedef enum logic {A_RAW, A_SCALED} a_sel_type;
   typedef enum logic {B_SCALE, B_GAIN} b_sel_type;
   typedef enum logic [1:0] {ACC_HOLD, ACC_LOAD, ACC_ADD} acc_op_type;
   typedef enum logic [1:0] {J_NEXT, J_LOOP, J_END, J_OUT} jump_type;

   typedef struct packed {
      a_sel_type        a_sel;
      b_sel_type        b_sel;
      logic [1:0]       mul_idx;
      logic             sv_wr;
      logic [1:0]       sv_idx;
      acc_op_type       acc_op;
      logic             tgt_wr;
      logic             diff_en;
      logic             lvl_wr;
      jump_type         jump;
      logic [PC_W-1:0]  jmp_addr;
   } ucode_type;

   typedef struct packed {
      ucode_type uc;
      logic      active;
      logic      out_load;
   } seq_ctl_type;

   typedef struct packed {
      logic                     operation;
      logic signed [VEL_W-1:0]  cmd_x;
      logic signed [VEL_W-1:0]  cmd_y;
      logic signed [VEL_W-1:0]  cmd_rot;
      logic                     halt;
   } req_payload_type;

   typedef struct packed {
      logic signed [LEVEL_W-1:0] level_0;
      logic signed [LEVEL_W-1:0] level_1;
      logic signed [LEVEL_W-1:0] level_2;
      logic signed [LEVEL_W-1:0] level_3;
   } rsp_payload_type;

   // Control store. Steps 0 to 9 mix a command, steps 10 to 12 run a tick.
   function automatic ucode_type ucode_rom(input logic [PC_W-1:0] pc);
      ucode_type uc;
      uc.a_sel    = A_RAW;
      uc.b_sel    = B_SCALE;
      uc.mul_idx  = VEL_X;
      uc.sv_wr    = 1'b0;
      uc.sv_idx   = VEL_X;
      uc.acc_op   = ACC_HOLD;
      uc.tgt_wr   = 1'b0;
      uc.diff_en  = 1'b0;
      uc.lvl_wr   = 1'b0;
      uc.jump     = J_NEXT;
      uc.jmp_addr = UC_CMD;
      case (pc)
         4'd0: begin
            uc.mul_idx = VEL_X;
         end
         4'd1: begin
            uc.mul_idx = VEL_Y;
            uc.sv_wr   = 1'b1;
            uc.sv_idx  = VEL_X;
         end
         4'd2: begin
            uc.mul_idx = VEL_R;
            uc.sv_wr   = 1'b1;
            uc.sv_idx  = VEL_Y;
         end
         4'd3: begin
            uc.sv_wr  = 1'b1;
            uc.sv_idx = VEL_R;
         end
         4'd4: begin
            uc.a_sel   = A_SCALED;
            uc.b_sel   = B_GAIN;
            uc.mul_idx = VEL_X;
         end
         4'd5: begin
            uc.a_sel   = A_SCALED;
            uc.b_sel   = B_GAIN;
            uc.mul_idx = VEL_Y;
            uc.acc_op  = ACC_LOAD;
         end
         4'd6: begin
            uc.a_sel   = A_SCALED;
            uc.b_sel   = B_GAIN;
            uc.mul_idx = VEL_R;
            uc.acc_op  = ACC_ADD;
         end
         4'd7: begin
            uc.acc_op = ACC_ADD;
         end
         4'd8: begin
            uc.tgt_wr   = 1'b1;
            uc.jump     = J_LOOP;
            uc.jmp_addr = UC_MIX;
         end
         4'd9: begin
            uc.jump = J_END;
         end
         4'd10: begin
            uc.diff_en = 1'b1;
         end
         4'd11: begin
            uc.lvl_wr   = 1'b1;
            uc.jump     = J_LOOP;
            uc.jmp_addr = UC_TICK;
         end
         4'd12: begin
            uc.jump = J_OUT;
         end
         default: begin
            uc.jump = J_END;
         end
      endcase
      return uc;
   endfunction

endpackage

FILE: rtl/wms_chan_if.sv
`timescale 1ns / 1ps

interface wms_req_if import wms_pkg::*; ();
   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface wms_rsp_if import wms_pkg::*; ();
   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface wms_csr_if import wms_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CSR_DAT_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/wms_seq.sv
`timescale 1ns / 1ps

module wms_seq import wms_pkg::*; #(
   parameter int WHEELS = WHEELS_DEF,
   localparam int WIDX_W = (WHEELS > 1) ? $clog2(WHEELS) : 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              start_op,
   input  logic              out_free,
   output logic [WIDX_W-1:0] wheel,
   output seq_ctl_type       ctl
);

   logic              busy_ff, busy_in;
   logic [PC_W-1:0]   pc_ff, pc_in;
   logic [WIDX_W-1:0] wheel_ff, wheel_in;
   ucode_type         uc;
   logic              last_wheel;
   logic              out_load;

   assign uc         = ucode_rom(pc_ff);
   assign last_wheel = (wheel_ff == WIDX_W'(WHEELS - 1));

   always_comb begin
      busy_in  = busy_ff;
      pc_in    = pc_ff;
      wheel_in = wheel_ff;
      out_load = 1'b0;
      if (!busy_ff) begin
         if (start) begin
            busy_in  = 1'b1;
            pc_in    = (start_op == OP_TICK) ? UC_TICK : UC_CMD;
            wheel_in = '0;
         end
      end else begin
         case (uc.jump)
            J_NEXT: pc_in = pc_ff + PC_W'(1);
            J_LOOP: begin
               if (last_wheel) begin
                  pc_in = pc_ff + PC_W'(1);
               end else begin
                  wheel_in = wheel_ff + WIDX_W'(1);
                  pc_in    = uc.jmp_addr;
               end
            end
            J_END: busy_in = 1'b0;
            J_OUT: begin
               // Hold here until the result register can take the levels.
               if (out_free) begin
                  out_load = 1'b1;
                  busy_in  = 1'b0;
               end
            end
            default: busy_in = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         pc_ff    <= UC_CMD;
         wheel_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         pc_ff    <= pc_in;
         wheel_ff <= wheel_in;
      end
   end

   assign wheel        = wheel_ff;
   assign ctl.uc       = uc;
   assign ctl.active   = busy_ff;
   assign ctl.out_load = out_load;

endmodule

FILE: rtl/wheel_mix_slew_limiter_core.sv
`timescale 1ns / 1ps

// Holonomic wheel mixer with a per-tick slew limiter. A command transaction
// (operation 0) scales the x, y and rotation velocities by speed_scale, dots
// them with each wheel's gain row on one shared multiplier and stores the
// saturated 32-bit targets; it returns nothing. A tick transaction
// (operation 1) moves each level toward its target by at most slew_step,
// or clears every level when halt is set, and returns one transaction with
// the four levels, after any wait for the result register to empty. The
// microprogram spends one step per multiply and two steps per wheel on the
// slew update. A new request is taken the cycle after the program ends,
// while an earlier result may still wait in the output register. Wheels at
// WHEELS and above always report zero.
module wheel_mix_slew_limiter_core import wms_pkg::*; #(
   parameter int WHEELS = WHEELS_DEF
) (
   input logic        clock,
   input logic        reset,
   wms_req_if.sink    req_chan,
   wms_rsp_if.source  rsp_chan,
   wms_csr_if.sink    csr_chan
);

   localparam int WIDX_W = (WHEELS > 1) ? $clog2(WHEELS) : 1;
   localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(2147483647);
   localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

   seq_ctl_type       ctl;
   logic [WIDX_W-1:0] wheel;
   logic              req_fire, csr_fire, rsp_fire, out_free;

   // Configuration
   logic [ROW_W-1:0]   gain_row_ff [WHEELS];
   logic [ROW_W-1:0]   gain_row_in [WHEELS];
   logic [SCALE_W-1:0] speed_scale_ff, speed_scale_in;
   logic [STEP_W-1:0]  slew_step_ff, slew_step_in;

   // Captured request
   logic signed [VEL_W-1:0] cmd_x_ff, cmd_y_ff, cmd_rot_ff;
   logic                    halt_ff;

   // Datapath
   logic signed [SVEL_W-1:0]  sv_ff [3];
   logic signed [SVEL_W-1:0]  sv_in [3];
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic signed [DIFF_W-1:0]  diff_ff, diff_in;
   logic signed [LEVEL_W-1:0] target_ff [WHEELS];
   logic signed [LEVEL_W-1:0] target_in [WHEELS];
   logic signed [LEVEL_W-1:0] level_ff [WHEELS];
   logic signed [LEVEL_W-1:0] level_in [WHEELS];

   logic signed [VEL_W-1:0]   raw_vel;
   logic signed [SVEL_W-1:0]  a_op;
   logic signed [GAIN_W-1:0]  gain_op, b_op;
   logic [ROW_W-1:0]          gain_row;
   logic signed [LEVEL_W-1:0] sat_val;
   logic signed [DIFF_W-1:0]  step_s;
   logic signed [LEVEL_W-1:0] slewed;

   // Result register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [LEVEL_W-1:0] rsp_level_ff [MAX_WHEELS];
   logic signed [LEVEL_W-1:0] rsp_level_in [MAX_WHEELS];

   assign req_fire       = req_chan.valid && req_chan.ready;
   assign csr_fire       = csr_chan.valid && csr_chan.ready;
   assign rsp_fire       = rsp_valid_ff && rsp_chan.ready;
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = !ctl.active;
   assign csr_chan.ready = 1'b1;

   wms_seq #(.WHEELS(WHEELS)) u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (req_fire),
      .start_op (req_chan.payload.operation),
      .out_free (out_free),
      .wheel    (wheel),
      .ctl      (ctl)
   );

   // Configuration writes; gain rows of absent wheels are not kept.
   always_comb begin
      gain_row_in    = gain_row_ff;
      speed_scale_in = speed_scale_ff;
      slew_step_in   = slew_step_ff;
      if (csr_fire) begin
         if (csr_chan.index < CSR_IDX_W'(WHEELS)) begin
            gain_row_in[csr_chan.index[WIDX_W-1:0]] = csr_chan.data;
         end else if (csr_chan.index == CSR_SPEED_SCALE) begin
            speed_scale_in = csr_chan.data[SCALE_W-1:0];
         end else if (csr_chan.index == CSR_SLEW_STEP) begin
            slew_step_in = csr_chan.data[STEP_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WHEELS; i++) begin
            gain_row_ff[i] <= '0;
         end
         speed_scale_ff <= SPEED_SCALE_RST;
         slew_step_ff   <= SLEW_STEP_RST;
      end else begin
         gain_row_ff    <= gain_row_in;
         speed_scale_ff <= speed_scale_in;
         slew_step_ff   <= slew_step_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         cmd_x_ff   <= req_chan.payload.cmd_x;
         cmd_y_ff   <= req_chan.payload.cmd_y;
         cmd_rot_ff <= req_chan.payload.cmd_rot;
         halt_ff    <= req_chan.payload.halt;
      end
   end

   // Shared multiplier operands
   assign gain_row = gain_row_ff[wheel];

   always_comb begin
      case (ctl.uc.mul_idx)
         VEL_X: begin
            raw_vel = cmd_x_ff;
            gain_op = gain_row[GAIN_W-1:0];
         end
         VEL_Y: begin
            raw_vel = cmd_y_ff;
            gain_op = gain_row[2*GAIN_W-1:GAIN_W];
         end
         default: begin
            raw_vel = cmd_rot_ff;
            gain_op = gain_row[3*GAIN_W-1:2*GAIN_W];
         end
      endcase
      if (ctl.uc.a_sel == A_SCALED) begin
         case (ctl.uc.mul_idx)
            VEL_X:   a_op = sv_ff[0];
            VEL_Y:   a_op = sv_ff[1];
            default: a_op = sv_ff[2];
         endcase
      end else begin
         a_op = SVEL_W'(raw_vel);
      end
      b_op    = (ctl.uc.b_sel == B_GAIN) ? gain_op
                                         : $signed({{(GAIN_W-SCALE_W){1'b0}}, speed_scale_ff});
      prod_in = PROD_W'(a_op) * PROD_W'(b_op);
   end

   always_comb begin
      sv_in = sv_ff;
      if (ctl.active && ctl.uc.sv_wr) begin
         case (ctl.uc.sv_idx)
            VEL_X:   sv_in[0] = prod_ff[SVEL_W-1:0];
            VEL_Y:   sv_in[1] = prod_ff[SVEL_W-1:0];
            default: sv_in[2] = prod_ff[SVEL_W-1:0];
         endcase
      end
      case (ctl.uc.acc_op)
         ACC_LOAD: acc_in = ACC_W'(prod_ff);
         ACC_ADD:  acc_in = acc_ff + ACC_W'(prod_ff);
         default:  acc_in = acc_ff;
      endcase
   end

   always_comb begin
      if (acc_ff > SAT_HI) begin
         sat_val = LEVEL_W'(SAT_HI);
      end else if (acc_ff < SAT_LO) begin
         sat_val = LEVEL_W'(SAT_LO);
      end else begin
         sat_val = acc_ff[LEVEL_W-1:0];
      end
      target_in = target_ff;
      if (ctl.active && ctl.uc.tgt_wr) begin
         target_in[wheel] = sat_val;
      end
   end

   // Slew: the distance is registered first, then the step is chosen.
   assign diff_in = ctl.uc.diff_en ? DIFF_W'(target_ff[wheel]) - DIFF_W'(level_ff[wheel])
                                   : diff_ff;
   assign step_s  = $signed({{(DIFF_W-STEP_W){1'b0}}, slew_step_ff});

   always_comb begin
      if (halt_ff) begin
         slewed = '0;
      end else if (diff_ff > step_s) begin
         slewed = level_ff[wheel] + LEVEL_W'(slew_step_ff);
      end else if (diff_ff < -step_s) begin
         slewed = level_ff[wheel] - LEVEL_W'(slew_step_ff);
      end else begin
         slewed = target_ff[wheel];
      end
      level_in = level_ff;
      if (ctl.active && ctl.uc.lvl_wr) begin
         level_in[wheel] = slewed;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      diff_ff <= diff_in;
      sv_ff   <= sv_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WHEELS; i++) begin
            target_ff[i] <= '0;
            level_ff[i]  <= '0;
         end
      end else begin
         target_ff <= target_in;
         level_ff  <= level_in;
      end
   end

   // Result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_level_in = rsp_level_ff;
      if (ctl.out_load) begin
         rsp_valid_in = 1'b1;
         for (int i = 0; i < MAX_WHEELS; i++) begin
            rsp_level_in[i] = (i < WHEELS) ? level_ff[i] : '0;
         end
      end else if (rsp_fire) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_level_ff <= rsp_level_in;
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.payload.level_0 = rsp_level_ff[0];
   assign rsp_chan.payload.level_1 = rsp_level_ff[1];
   assign rsp_chan.payload.level_2 = rsp_level_ff[2];
   assign rsp_chan.payload.level_3 = rsp_level_ff[3];

endmodule
